// ===== hw/rtl/dlog_pkg.sv =====
// Shared types and constants for the discrete log engine.
`timescale 1ns / 1ps
`default_nettype none
package dlog_pkg;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RED_A,
		ST_RED_B,
		ST_CLEAR,
		ST_GCD_INIT,
		ST_GCD_DIV,
		ST_GCD_CHK,
		ST_STRIP_B,
		ST_STRIP_M,
		ST_STRIP_AG,
		ST_STRIP_R,
		ST_STRIP_K,
		ST_SQRT,
		ST_GP_MUL,
		ST_BABY_PUT,
		ST_BABY_RD,
		ST_BABY_CHK,
		ST_BABY_MUL,
		ST_GIANT_MUL,
		ST_GIANT_RD,
		ST_GIANT_CHK,
		ST_DONE
	} dlog_state_t;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIV
	} dlog_op_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dlog_arith.sv =====
// Bit-serial modular multiplier and restoring divider, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module dlog_arith #(
	parameter int W = 24
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           go,
	input  wire dlog_pkg::dlog_op_t op,
	input  wire logic [W-1:0]   x,
	input  wire logic [W-1:0]   y,
	input  wire logic [W-1:0]   m,
	output logic                done,
	output logic [W-1:0]        quo,
	output logic [W-1:0]        res
);
	localparam int CW = $clog2(W + 1);

	logic              busy_q;
	dlog_pkg::dlog_op_t op_q;
	logic [CW-1:0]     cnt_q;
	logic [W-1:0]      sh_q;
	logic [W-1:0]      add_q;
	logic [W-1:0]      m_q;
	logic [W-1:0]      acc_q;
	logic [W-1:0]      q_q;
	logic [W:0]        dbl;
	logic [W:0]        dbl_add;
	logic [W:0]        rem_sh;

	always_comb begin
		dbl = {acc_q, 1'b0};
		if (dbl >= {1'b0, m_q}) dbl = dbl - {1'b0, m_q};
		dbl_add = dbl;
		if (sh_q[W-1]) begin
			dbl_add = dbl + {1'b0, add_q};
			if (dbl_add >= {1'b0, m_q}) dbl_add = dbl_add - {1'b0, m_q};
		end
		rem_sh = {acc_q, sh_q[W-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
			op_q   <= dlog_pkg::OP_MUL;
		end else begin
			done <= 1'b0;
			if (go && !busy_q && !done) begin
				busy_q <= 1'b1;
				op_q   <= op;
				cnt_q  <= CW'(W);
				sh_q   <= x;
				add_q  <= y;
				m_q    <= m;
				acc_q  <= '0;
				q_q    <= '0;
			end else if (busy_q) begin
				sh_q <= {sh_q[W-2:0], 1'b0};
				if (op_q == dlog_pkg::OP_MUL) begin
					acc_q <= dbl_add[W-1:0];
				end else if (rem_sh >= {1'b0, add_q}) begin
					acc_q <= W'(rem_sh - {1'b0, add_q});
					q_q   <= {q_q[W-2:0], 1'b1};
				end else begin
					acc_q <= rem_sh[W-1:0];
					q_q   <= {q_q[W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign res = acc_q;
	assign quo = q_q;

`ifndef NO_ASSERTIONS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy_q) else $error("done while busy");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0) else $error("count zero while busy");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/discrete_log_bsgs_top.sv =====
// Top level of the baby-step giant-step discrete log engine.
//
// Raise start with base, target and modulus while busy is low; the
// transaction is taken at that edge and busy stays high until the answer.
// The answer shows on found and exponent for one cycle with done high;
// the receiver cannot stall it, so it must sample that cycle. busy is low
// in that cycle, so the next transaction may be taken there.
// Every multiply, remainder and quotient runs on one shared bit-serial
// unit. A query costs two reductions, a sweep to clear the table, one
// remainder per gcd step plus five operations per stripped factor, a
// bitwise square root, then about 3*sqrt(m) multiplies (giant power,
// baby and giant steps); each baby and giant step is followed by one or
// more probes of the hash table memory (one read port).
// Reset clears the control state; the table valid bits are a separate
// memory swept clear, over all TABLE_DEPTH entries, after the reductions.
// A zero modulus goes straight to the done state and answers not-found.
`timescale 1ns / 1ps
`default_nettype none
module discrete_log_bsgs_top #(
	parameter int MOD_BITS    = 24,
	parameter int TABLE_DEPTH = 8192
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [MOD_BITS-1:0] base,
	input  wire logic [MOD_BITS-1:0] target,
	input  wire logic [MOD_BITS-1:0] modulus,
	output logic                     done,
	output logic                     found,
	output logic [24:0]              exponent
);
	localparam int W  = MOD_BITS;
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int SW = W / 2 + 2;

	dlog_pkg::dlog_state_t st_q, st_d;

	logic [W-1:0] a_q, b_q, m_q, k_q, g_q, gx_q, gy_q, gp_q, walk_q, n_q, cnt_q;
	logic [4:0]   strip_q;
	logic [W-1:0] sv_q, sr_q;
	logic [W+1:0] sb_q;
	logic [AW:0]  clr_q;
	logic [AW-1:0] slot_q;
	logic [AW:0]  probe_q;

	logic         mgo;
	dlog_pkg::dlog_op_t mop;
	logic [W-1:0] mx, my, mm, mquo, mres;
	logic         mdone;

	logic [W-1:0]  key_mem [TABLE_DEPTH];
	logic [SW-1:0] step_mem [TABLE_DEPTH];
	logic          val_mem [TABLE_DEPTH];
	logic [W-1:0]  rkey;
	logic [SW-1:0] rstep;
	logic          rval;
	logic          we_key, we_val;
	logic          vwe;
	logic [AW-1:0] vaddr;
	logic          vdat;

	dlog_arith #(.W(W)) u_arith (
		.clk, .arst_n, .go(mgo), .op(mop), .x(mx), .y(my), .m(mm),
		.done(mdone), .quo(mquo), .res(mres)
	);

	always_ff @(posedge clk) begin
		if (vwe) val_mem[vaddr] <= vdat;
		if (we_key) begin
			key_mem[slot_q]  <= walk_q;
			step_mem[slot_q] <= SW'(cnt_q);
		end
		rkey  <= key_mem[slot_q];
		rstep <= step_mem[slot_q];
		rval  <= val_mem[slot_q];
	end

	assign vwe   = (st_q == dlog_pkg::ST_CLEAR) || we_val;
	assign vaddr = (st_q == dlog_pkg::ST_CLEAR) ? clr_q[AW-1:0] : slot_q;
	assign vdat  = (st_q != dlog_pkg::ST_CLEAR);

	logic [W+1:0] sq_try;
	assign sq_try = {2'b00, sr_q} + sb_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			dlog_pkg::ST_IDLE:
				if (start) st_d = (modulus == '0) ? dlog_pkg::ST_DONE : dlog_pkg::ST_RED_A;
			dlog_pkg::ST_RED_A:   if (mdone) st_d = dlog_pkg::ST_RED_B;
			dlog_pkg::ST_RED_B:   if (mdone) st_d = dlog_pkg::ST_CLEAR;
			dlog_pkg::ST_CLEAR:
				if (clr_q == (AW+1)'(TABLE_DEPTH - 1)) st_d = dlog_pkg::ST_GCD_INIT;
			dlog_pkg::ST_GCD_INIT: st_d = dlog_pkg::ST_GCD_DIV;
			dlog_pkg::ST_GCD_DIV:
				if (gy_q == '0) st_d = dlog_pkg::ST_GCD_CHK;
				else if (mdone) st_d = dlog_pkg::ST_GCD_DIV;
			dlog_pkg::ST_GCD_CHK:
				if (gx_q <= W'(1)) st_d = dlog_pkg::ST_SQRT;
				else if (b_q == k_q) st_d = dlog_pkg::ST_DONE;
				else st_d = dlog_pkg::ST_STRIP_B;
			dlog_pkg::ST_STRIP_B:
				if (mdone) st_d = (mres != '0) ? dlog_pkg::ST_DONE : dlog_pkg::ST_STRIP_M;
			dlog_pkg::ST_STRIP_M:  if (mdone) st_d = dlog_pkg::ST_STRIP_AG;
			dlog_pkg::ST_STRIP_AG: if (mdone) st_d = dlog_pkg::ST_STRIP_R;
			dlog_pkg::ST_STRIP_R:  if (mdone) st_d = dlog_pkg::ST_STRIP_K;
			dlog_pkg::ST_STRIP_K:  if (mdone) st_d = dlog_pkg::ST_GCD_INIT;
			dlog_pkg::ST_SQRT:     if (sb_q == '0) st_d = dlog_pkg::ST_GP_MUL;
			dlog_pkg::ST_GP_MUL:
				if (cnt_q == n_q) st_d = dlog_pkg::ST_BABY_PUT;
			dlog_pkg::ST_BABY_PUT: st_d = dlog_pkg::ST_BABY_RD;
			dlog_pkg::ST_BABY_RD:  st_d = dlog_pkg::ST_BABY_CHK;
			dlog_pkg::ST_BABY_CHK:
				if (!rval || rkey == walk_q || probe_q == (AW+1)'(TABLE_DEPTH - 1))
					st_d = (cnt_q == n_q) ? dlog_pkg::ST_GIANT_MUL : dlog_pkg::ST_BABY_MUL;
				else st_d = dlog_pkg::ST_BABY_RD;
			dlog_pkg::ST_BABY_MUL: if (mdone) st_d = dlog_pkg::ST_BABY_PUT;
			dlog_pkg::ST_GIANT_MUL: if (mdone) st_d = dlog_pkg::ST_GIANT_RD;
			dlog_pkg::ST_GIANT_RD: st_d = dlog_pkg::ST_GIANT_CHK;
			dlog_pkg::ST_GIANT_CHK:
				if (rval && rkey == walk_q) st_d = dlog_pkg::ST_DONE;
				else if (!rval || probe_q == (AW+1)'(TABLE_DEPTH - 1))
					st_d = (cnt_q == n_q) ? dlog_pkg::ST_DONE : dlog_pkg::ST_GIANT_MUL;
				else st_d = dlog_pkg::ST_GIANT_RD;
			dlog_pkg::ST_DONE: st_d = dlog_pkg::ST_IDLE;
			default: st_d = dlog_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		mgo = 1'b0;
		mop = dlog_pkg::OP_DIV;
		mx  = '0;
		my  = W'(1);
		mm  = m_q;
		we_key = 1'b0;
		we_val = 1'b0;
		unique case (st_q)
			dlog_pkg::ST_RED_A: begin mgo = 1'b1; mx = a_q; my = m_q; end
			dlog_pkg::ST_RED_B: begin mgo = 1'b1; mx = b_q; my = m_q; end
			dlog_pkg::ST_GCD_DIV: begin mgo = (gy_q != '0); mx = gx_q; my = gy_q; end
			dlog_pkg::ST_STRIP_B: begin mgo = 1'b1; mx = b_q; my = g_q; end
			dlog_pkg::ST_STRIP_M: begin mgo = 1'b1; mx = m_q; my = g_q; end
			dlog_pkg::ST_STRIP_AG: begin mgo = 1'b1; mx = a_q; my = g_q; end
			dlog_pkg::ST_STRIP_R: begin mgo = 1'b1; mx = gp_q; my = m_q; end
			dlog_pkg::ST_STRIP_K: begin
				mgo = 1'b1; mop = dlog_pkg::OP_MUL; mx = k_q; my = gp_q;
			end
			dlog_pkg::ST_GP_MUL: begin
				mgo = (cnt_q != n_q); mop = dlog_pkg::OP_MUL; mx = a_q; my = gp_q;
			end
			dlog_pkg::ST_BABY_CHK: begin
				if (!rval || rkey == walk_q) begin
					we_key = 1'b1;
					we_val = !rval;
				end
			end
			dlog_pkg::ST_BABY_MUL: begin
				mgo = 1'b1; mop = dlog_pkg::OP_MUL; mx = a_q; my = walk_q;
			end
			dlog_pkg::ST_GIANT_MUL: begin
				mgo = 1'b1; mop = dlog_pkg::OP_MUL; mx = walk_q; my = gp_q;
			end
			default: ;
		endcase
	end

	logic [W-1:0] ared;
	assign ared = a_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= dlog_pkg::ST_IDLE;
			done     <= 1'b0;
			found    <= 1'b0;
			exponent <= '0;
			strip_q  <= '0;
			clr_q    <= '0;
		end else begin
			st_q <= st_d;
			done <= 1'b0;
			unique case (st_q)
				dlog_pkg::ST_IDLE: if (start) begin
					a_q <= base; b_q <= target; m_q <= modulus;
					found <= 1'b0; exponent <= '0;
					strip_q <= '0; clr_q <= '0;
				end
				dlog_pkg::ST_RED_A: if (mdone) a_q <= mres;
				dlog_pkg::ST_RED_B: if (mdone) begin
					b_q <= mres;
					k_q <= (m_q == W'(1)) ? '0 : W'(1);
				end
				dlog_pkg::ST_CLEAR: clr_q <= clr_q + 1'b1;
				dlog_pkg::ST_GCD_INIT: begin gx_q <= ared; gy_q <= m_q; end
				dlog_pkg::ST_GCD_DIV: begin
					if (gy_q == '0) g_q <= gx_q;
					else if (mdone) begin gx_q <= gy_q; gy_q <= mres; end
				end
				dlog_pkg::ST_GCD_CHK: begin
					if (gx_q > W'(1) && b_q == k_q) begin
						found <= 1'b1; exponent <= 25'(strip_q);
					end
					sv_q <= m_q; sr_q <= '0;
					sb_q <= (W+2)'(1) << (2 * ((W + 1) / 2));
				end
				dlog_pkg::ST_STRIP_B: if (mdone) b_q <= mquo;
				dlog_pkg::ST_STRIP_M: if (mdone) begin
					m_q <= mquo; strip_q <= strip_q + 1'b1;
				end
				dlog_pkg::ST_STRIP_AG: if (mdone) gp_q <= mquo;
				dlog_pkg::ST_STRIP_R: if (mdone) gp_q <= mres;
				dlog_pkg::ST_STRIP_K: if (mdone) k_q <= mres;
				dlog_pkg::ST_SQRT: begin
					if (sb_q != '0) begin
						if ({2'b00, sv_q} >= sq_try) begin
							sv_q <= W'({2'b00, sv_q} - sq_try);
							sr_q <= W'(({2'b00, sr_q} >> 1) + sb_q);
						end else sr_q <= sr_q >> 1;
						sb_q <= sb_q >> 2;
					end else begin
						n_q <= sr_q + 1'b1;
						cnt_q <= '0;
						gp_q <= (m_q == W'(1)) ? '0 : W'(1);
					end
				end
				dlog_pkg::ST_GP_MUL: begin
					if (mdone) begin gp_q <= mres; cnt_q <= cnt_q + 1'b1; end
					if (cnt_q == n_q) begin
						cnt_q <= '0; walk_q <= b_q;
						slot_q <= b_q[AW-1:0]; probe_q <= '0;
					end
				end
				dlog_pkg::ST_BABY_CHK: begin
					if (!rval || rkey == walk_q || probe_q == (AW+1)'(TABLE_DEPTH - 1)) begin
						if (cnt_q == n_q) begin cnt_q <= W'(1); walk_q <= k_q; end
					end else begin
						slot_q <= slot_q + 1'b1; probe_q <= probe_q + 1'b1;
					end
				end
				dlog_pkg::ST_BABY_MUL: if (mdone) begin
					walk_q <= mres; cnt_q <= cnt_q + 1'b1;
					slot_q <= mres[AW-1:0]; probe_q <= '0;
				end
				dlog_pkg::ST_GIANT_MUL: if (mdone) begin
					walk_q <= mres; slot_q <= mres[AW-1:0]; probe_q <= '0;
				end
				dlog_pkg::ST_GIANT_CHK: begin
					if (rval && rkey == walk_q) begin
						found <= 1'b1;
						exponent <= 25'(n_q * cnt_q - W'(rstep) + W'(strip_q));
					end else if (!rval || probe_q == (AW+1)'(TABLE_DEPTH - 1)) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						slot_q <= slot_q + 1'b1; probe_q <= probe_q + 1'b1;
					end
				end
				dlog_pkg::ST_DONE: done <= 1'b1;
				default: ;
			endcase
		end
	end

	assign busy = (st_q != dlog_pkg::ST_IDLE);

`ifndef NO_ASSERTIONS
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done repeated");
	a_found_exp: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> exponent == '0) else $error("exponent without hit");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("start not taken");
`endif
endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the baby-step giant-step discrete log engine.
`timescale 1ns / 1ps
module tb;

	localparam int W = 24;
	localparam longint unsigned CYCLE_LIMIT = 64'd40_000_000;

	logic            clk;
	logic            arst_n;
	logic            start;
	logic            busy;
	logic [W-1:0]    base;
	logic [W-1:0]    target;
	logic [W-1:0]    modulus;
	logic            done;
	logic            found;
	logic [24:0]     exponent;
	longint unsigned cycles;

	discrete_log_bsgs_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.base(base), .target(target), .modulus(modulus),
		.done(done), .found(found), .exponent(exponent)
	);

	typedef struct {
		bit         hit;
		logic [24:0] power;
	} dlog_answer_t;

	function automatic longint unsigned mul_mod(longint unsigned x, longint unsigned y,
			longint unsigned m);
		return ((x % m) * (y % m)) % m;
	endfunction

	function automatic longint unsigned pow_mod(longint unsigned a, longint unsigned x,
			longint unsigned m);
		longint unsigned r;
		r = 1 % m;
		a = a % m;
		while (x != 0) begin
			if (x[0]) r = mul_mod(r, a, m);
			a = mul_mod(a, a, m);
			x = x >> 1;
		end
		return r;
	endfunction

	function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
		longint unsigned t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r;
		longint unsigned c;
		r = 0;
		for (int bitpos = 15; bitpos >= 0; bitpos--) begin
			c = r | (64'd1 << bitpos);
			if (c * c <= v) r = c;
		end
		return r;
	endfunction

	class answer_board;
		dlog_answer_t pending_q[$];
		int           errors;

		function automatic dlog_answer_t solve_dlog(longint unsigned a0, longint unsigned b0,
				longint unsigned m0);
			dlog_answer_t    res;
			longint unsigned a, b, m, g, k, n, gp, w;
			int unsigned     strips;
			int unsigned     step_of[longint unsigned];
			res.hit = 0;
			res.power = '0;
			if (m0 == 0) return res;
			m = m0;
			a = a0 % m;
			b = b0 % m;
			k = 1 % m;
			strips = 0;
			g = gcd_of(a, m);
			while (g > 1) begin
				if (b == k) begin
					res.hit = 1;
					res.power = 25'(strips);
					return res;
				end
				if (b % g != 0) return res;
				b = b / g;
				m = m / g;
				strips = (strips + 1) & 31;
				k = mul_mod(k, a / g, m);
				g = gcd_of(a, m);
			end
			n = root_floor(m) + 1;
			gp = 1 % m;
			for (longint unsigned q = 0; q < n; q++) gp = mul_mod(gp, a, m);
			w = b;
			for (longint unsigned q = 0; q <= n; q++) begin
				step_of[w] = q;
				w = mul_mod(w, a, m);
			end
			w = k;
			for (longint unsigned p = 1; p <= n; p++) begin
				w = mul_mod(w, gp, m);
				if (step_of.exists(w)) begin
					res.hit = 1;
					res.power = 25'(n * p - step_of[w] + strips);
					return res;
				end
			end
			return res;
		endfunction

		function void note_query(longint unsigned a, longint unsigned b, longint unsigned m);
			pending_q.push_back(solve_dlog(a, b, m));
		endfunction

		function void check_answer(bit f, logic [24:0] e);
			dlog_answer_t want;
			if (pending_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected answer found=%0d exponent=%0d", f, e);
				return;
			end
			want = pending_q.pop_front();
			if (f !== want.hit || e !== want.power) begin
				errors++;
				if (errors <= 10)
					$display("answer differs: expected found=%0d exponent=%0d, got found=%0d exponent=%0d",
						want.hit, want.power, f, e);
			end
		endfunction
	endclass

	answer_board board;
	int          burst_left;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycles <= 0;
		end else begin
			cycles <= cycles + 1;
			if (cycles > CYCLE_LIMIT) begin
				$display("discrete_log_bsgs_top: mismatch");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) board.check_answer(found, exponent);
	end

	task automatic send_query(longint unsigned a, longint unsigned b, longint unsigned m);
		int gap;
		start <= 1'b1;
		base <= a[W-1:0];
		target <= b[W-1:0];
		modulus <= m[W-1:0];
		do @(posedge clk); while (busy);
		board.note_query(a[W-1:0], b[W-1:0], m[W-1:0]);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 6);
			gap = $urandom_range(1, 25);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic hold_until_drained();
		start <= 1'b0;
		@(posedge clk);
		while (board.pending_q.size() != 0) @(posedge clk);
	endtask

	task automatic send_random();
		longint unsigned m, a, b, r, g, top;
		int unsigned     kind;
		kind = $urandom_range(0, 9);
		if ($urandom_range(0, 9) == 0) m = $urandom_range(1024, 65535);
		else m = $urandom_range(2, 1023);
		a = $urandom_range(0, 24'hFFFFFF);
		b = $urandom_range(0, 24'hFFFFFF);
		if (kind < 6) begin
			if (kind < 2) begin
				g = $urandom_range(2, 9);
				m = g * $urandom_range(1, 120);
				a = g * $urandom_range(0, 24'hFFFFFF / g);
			end
			r = pow_mod(a, $urandom_range(0, 2 * m), m);
			top = (24'hFFFFFF - r) / m;
			b = r + m * $urandom_range(0, top);
		end
		send_query(a, b, m);
	endtask

	initial begin
		board = new();
		burst_left = 0;
		arst_n = 1'b0;
		start = 1'b0;
		base = '0;
		target = '0;
		modulus = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_query(0, 0, 0);
		send_query(7, 24'hFFFFFF, 0);
		send_query(5, 3, 1);
		send_query(0, 0, 1);
		send_query(3, 13, 17);
		send_query(2, 3, 7);
		send_query(0, 0, 10);
		send_query(0, 1, 10);
		send_query(6, 4, 8);
		send_query(4, 2, 8);
		send_query(2, 0, 8);
		send_query(12, 36, 60);
		send_query(24'hFFFFFF, 1, 2);
		send_query(1, 5, 7);
		send_query(24'hFFFFFF, 0, 24'h800000);
		send_query(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		send_query(2, 24'hABCDEF, 24'hFFFFFD);
		send_query(24'h555555, 24'hAAAAAA, 24'h000FFF);
		hold_until_drained();

		repeat (100) send_random();
		start <= 1'b0;

		@(posedge clk);
		while (board.pending_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (board.errors == 0) begin
			$display("discrete_log_bsgs_top: match");
		end else begin
			$display("discrete_log_bsgs_top: mismatch");
		end
		$finish;
	end

endmodule
